FILE: rtl/mlc_pkg.sv
// Shared types and codes for the motion light controller.
// No dependencies; every other file takes names from here by scope.
package mlc_pkg;

    localparam int unsigned LIGHT_W   = 16;
    localparam int unsigned BATT_W    = 16;
    localparam int unsigned THRESH_W  = 16;
    localparam int unsigned LAMP_W    = 24;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned SETTLE_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 24;

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_ON       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE        = 3'd5;

    // lamp action codes
    localparam logic [1:0] LAMP_NONE = 2'd0;
    localparam logic [1:0] LAMP_OFF  = 2'd1;
    localparam logic [1:0] LAMP_ON   = 2'd2;

    // sensor power action codes
    localparam logic [1:0] SENS_NONE    = 2'd0;
    localparam logic [1:0] SENS_ENABLE  = 2'd1;
    localparam logic [1:0] SENS_DISABLE = 2'd2;

    typedef struct packed {
        logic [LIGHT_W-1:0] light_level;
        logic               light_read_failed;
        logic               motion_pulse;
        logic [BATT_W-1:0]  battery_level;
    } t_tick;

    typedef struct packed {
        logic [1:0]        lamp_action;
        logic [BATT_W-1:0] lamp_battery_value;
        logic [1:0]        sensor_power_action;
        logic              battery_led_on;
        logic              locked_out;
    } t_result;

    typedef struct packed {
        logic [THRESH_W-1:0] dark_threshold;
        logic [THRESH_W-1:0] bright_threshold;
        logic [THRESH_W-1:0] battery_low_threshold;
        logic [LAMP_W-1:0]   lamp_on_ticks;
        logic [HOLD_W-1:0]   light_holdoff_ticks;
        logic [SETTLE_W-1:0] motion_settle_ticks;
    } t_cfg;

endpackage

FILE: rtl/mlc_tick_if.sv
// Valid/ready channel carrying one tick word.
// Depends on mlc_pkg for the payload type.
interface mlc_tick_if;
    logic          valid;
    logic          ready;
    mlc_pkg::t_tick payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mlc_result_if.sv
// Valid/ready channel carrying one result word.
// Depends on mlc_pkg for the payload type.
interface mlc_result_if;
    logic            valid;
    logic            ready;
    mlc_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mlc_cfg_regs.sv
// Configuration register file: six write-only registers with reset values.
// Depends on mlc_pkg.
module mlc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mlc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mlc_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    output mlc_pkg::t_cfg                       o_cfg
);

    mlc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold        <= 16'd0;
            r_cfg.bright_threshold      <= 16'hFFFF;
            r_cfg.battery_low_threshold <= 16'd0;
            r_cfg.lamp_on_ticks         <= 24'd1000;
            r_cfg.light_holdoff_ticks   <= 16'd50;
            r_cfg.motion_settle_ticks   <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mlc_pkg::REG_DARK_THRESH:   r_cfg.dark_threshold <= i_cfg_data[15:0];
                mlc_pkg::REG_BRIGHT_THRESH: r_cfg.bright_threshold <= i_cfg_data[15:0];
                mlc_pkg::REG_BATT_LOW:      r_cfg.battery_low_threshold <= i_cfg_data[15:0];
                mlc_pkg::REG_LAMP_ON:       r_cfg.lamp_on_ticks <= i_cfg_data[23:0];
                mlc_pkg::REG_HOLDOFF:       r_cfg.light_holdoff_ticks <= i_cfg_data[15:0];
                mlc_pkg::REG_SETTLE:        r_cfg.motion_settle_ticks <= i_cfg_data[15:0];
                default: ; // unmapped index, ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mlc_tick_core.sv
// Controller state and the single-pass next-state / result logic for one tick.
// Depends on mlc_pkg.
module mlc_tick_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mlc_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  mlc_pkg::t_tick   i_tick,
    output mlc_pkg::t_result o_result
);

    logic [mlc_pkg::LAMP_W-1:0]   r_lamp_cnt,   n_lamp_cnt;
    logic [mlc_pkg::HOLD_W-1:0]   r_hold_cnt,   n_hold_cnt;
    logic [mlc_pkg::SETTLE_W-1:0] r_settle_cnt, n_settle_cnt;
    logic                         r_armed,      n_armed;
    logic                         r_pending,    n_pending;
    logic                         r_alert,      n_alert;

    logic [mlc_pkg::LAMP_W-1:0]   on_load;
    logic [mlc_pkg::LAMP_W-1:0]   lamp_dec;
    logic                         is_dark;
    logic                         is_bright;
    mlc_pkg::t_result             res;

    assign on_load   = (i_cfg.lamp_on_ticks != '0) ? i_cfg.lamp_on_ticks
                                                   : mlc_pkg::LAMP_W'(1);
    assign lamp_dec  = r_lamp_cnt - mlc_pkg::LAMP_W'(1);
    assign is_dark   = i_tick.light_read_failed
                     | (i_tick.light_level < i_cfg.dark_threshold);
    assign is_bright = i_tick.light_level > i_cfg.bright_threshold;

    always_comb begin
        n_lamp_cnt   = r_lamp_cnt;
        n_hold_cnt   = r_hold_cnt;
        n_settle_cnt = r_settle_cnt;
        n_armed      = r_armed;
        n_pending    = r_pending;
        n_alert      = r_alert;
        res          = '0;

        if (r_alert) begin
            // lockout: report only, state frozen
            res.battery_led_on = 1'b1;
            res.locked_out     = 1'b1;
        end else begin
            if (r_armed && i_tick.motion_pulse) begin
                n_pending = 1'b1;
            end

            // lamp timer / light sensing, first match wins
            if (r_lamp_cnt != '0) begin
                n_lamp_cnt = lamp_dec;
                if (lamp_dec == '0) begin
                    res.lamp_action = mlc_pkg::LAMP_OFF;
                    n_hold_cnt      = i_cfg.light_holdoff_ticks;
                end
            end else if (r_hold_cnt != '0) begin
                n_hold_cnt = r_hold_cnt - mlc_pkg::HOLD_W'(1);
            end else if (is_dark) begin
                if (!r_armed) begin
                    n_armed                 = 1'b1;
                    res.sensor_power_action = mlc_pkg::SENS_ENABLE;
                    n_settle_cnt            = i_cfg.motion_settle_ticks;
                end
            end else if (is_bright) begin
                if (r_armed) begin
                    n_armed                 = 1'b0;
                    res.sensor_power_action = mlc_pkg::SENS_DISABLE;
                    n_pending               = 1'b0;
                end
            end

            // settle delay swallows motion; otherwise act on it
            if (n_settle_cnt != '0) begin
                n_settle_cnt = n_settle_cnt - mlc_pkg::SETTLE_W'(1);
                n_pending    = 1'b0;
            end else if (n_armed && n_pending) begin
                n_pending = 1'b0;
                if (n_lamp_cnt != '0) begin
                    n_lamp_cnt = on_load;
                end else if (i_tick.battery_level < i_cfg.battery_low_threshold) begin
                    res.sensor_power_action = mlc_pkg::SENS_DISABLE;
                    n_armed                 = 1'b0;
                    n_alert                 = 1'b1;
                    n_lamp_cnt              = '0;
                end else begin
                    n_lamp_cnt             = on_load;
                    res.lamp_action        = mlc_pkg::LAMP_ON;
                    res.lamp_battery_value = i_tick.battery_level;
                end
            end

            res.battery_led_on = n_alert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_cnt   <= '0;
            r_hold_cnt   <= '0;
            r_settle_cnt <= '0;
            r_armed      <= 1'b0;
            r_pending    <= 1'b0;
            r_alert      <= 1'b0;
        end else if (i_fire) begin
            r_lamp_cnt   <= n_lamp_cnt;
            r_hold_cnt   <= n_hold_cnt;
            r_settle_cnt <= n_settle_cnt;
            r_armed      <= n_armed;
            r_pending    <= n_pending;
            r_alert      <= n_alert;
        end
    end

    assign o_result = res;

endmodule

FILE: rtl/motion_light_controller_core.sv
// Top level of the motion light controller: input register, tick logic, result register.
// Depends on mlc_pkg, mlc_tick_if, mlc_result_if, mlc_cfg_regs and mlc_tick_core.
//
// Use:
//  - i_tick carries one timer-tick word (light reading, read-error flag, motion
//    pulse, battery reading); o_result returns exactly one result word per tick.
//  - Configuration is a plain write port (i_cfg_we / i_cfg_idx / i_cfg_data);
//    registers 0..5 as listed in mlc_pkg, other indices are ignored. Write only
//    while no tick is in flight.
//  - Path: an accepted word goes from the input register to the result register.
//  - Throughput: one word per cycle while o_result is not held off. The tick is
//    registered, evaluated by one pass of compares and counter decrements against
//    the state registers, and the result is registered; state is updated in the
//    same cycle, so the next word sees it straight away.
//  - Stalls: when o_result is held off, the result register keeps its word and the
//    input register can still take one more word; i_tick.ready drops only when
//    both registers are full.
//  - Reset (synchronous, active low): both registers empty, controller state and
//    configuration back to defaults (lamp off, sensor disarmed, no alert).
//  - Once the battery alert latches, every later tick reports lockout only.
module motion_light_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mlc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    mlc_tick_if.sink                          i_tick,
    mlc_result_if.source                      o_result
);

    mlc_pkg::t_cfg    cfg;
    mlc_pkg::t_result step_res;

    logic             r_in_valid;
    mlc_pkg::t_tick   r_in;
    logic             r_out_valid;
    mlc_pkg::t_result r_out;

    logic             out_free;
    logic             fire;

    // result slot is free if empty or being drained this cycle
    assign out_free     = !r_out_valid || o_result.ready;
    assign fire         = r_in_valid && out_free;
    assign i_tick.ready = !r_in_valid || out_free;

    mlc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mlc_tick_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_tick   (r_in),
        .o_result (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in <= i_tick.payload;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule

FILE: rtl/mlc_checker.sv
// Port-level checks for motion_light_controller_core, bound to the top level.
// Depends on mlc_pkg.
module mlc_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  mlc_pkg::t_result i_out_payload
);

    logic r_seen_alert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_alert <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_payload.battery_led_on) begin
            r_seen_alert <= 1'b1;
        end
    end

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("result word changed while stalled");

    // lockout words carry nothing but the alert
    a_lockout_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.locked_out |->
            i_out_payload.battery_led_on
            && i_out_payload.lamp_action == mlc_pkg::LAMP_NONE
            && i_out_payload.sensor_power_action == mlc_pkg::SENS_NONE
            && i_out_payload.lamp_battery_value == '0)
        else $error("lockout word carries an action");

    // battery value only rides with lamp on
    a_batt_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.lamp_action != mlc_pkg::LAMP_ON |->
            i_out_payload.lamp_battery_value == '0)
        else $error("battery value without lamp on");

    // alert is sticky until reset
    a_alert_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_alert |-> i_out_payload.battery_led_on)
        else $error("battery alert dropped");

endmodule

bind motion_light_controller_core mlc_checker u_mlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);
